FILE: rtl/vehicle_route_kinematics_step_defines.svh
// Assertion macros shared by the vehicle route kinematics RTL.
`ifndef VEHICLE_ROUTE_KINEMATICS_STEP_DEFINES_SVH
`define VEHICLE_ROUTE_KINEMATICS_STEP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VRK_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("vrk assertion failed");

// Next-cycle implication, checked outside reset.
`define VRK_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("vrk assertion failed");

`endif

FILE: rtl/vrk_pkg.sv
// Package with types and constants of the vehicle route kinematics block.
package vrk_pkg;

  localparam int unsigned MaxSegments = 64;

  localparam logic [15:0] MaxSpeedRst = 16'd8533;
  localparam logic [15:0] AccelRst    = 16'd512;
  localparam logic [15:0] DecelRst    = 16'd1024;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED = 2'd0,
    CFG_ACCEL     = 2'd1,
    CFG_DECEL     = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BEHIND   = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_REJECT   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    MODE_SPAWNING = 3'd0,
    MODE_DRIVING  = 3'd1,
    MODE_WAITING  = 3'd2,
    MODE_LIGHT    = 3'd3,
    MODE_ARRIVED  = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LIMIT, S_STEP, S_SPEED, S_DIST, S_POS, S_WRD, S_WCHK, S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  index;
    logic [31:0] segment_length;
    logic [15:0] segment_speed_limit;
    logic [31:0] spawn_time;
    logic [15:0] delta_t;
    logic [63:0] allows_mask;
    logic        follow_present;
    logic [31:0] follow_max_position;
    logic [15:0] follow_speed_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  mode;
    logic [31:0] position;
    logic [15:0] speed;
    logic [6:0]  route_position;
    logic [31:0] waiting_time;
    logic [31:0] arrival_time;
  } out_item_t;

endpackage

FILE: rtl/vehicle_route_kinematics_step.sv
// Top level of the vehicle route kinematics block: segment memory and tick sequencer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------
//   input    | start_i, busy_o      | in_item_i  (in_item_t)
//   result   | done_o (one cycle)   | out_item_o (out_item_t)
//   config   | cfg_we_i, cfg_idx_i  | cfg_wdata_i (16 bits)
//
// Loads, starts and ticks that do not move go from the accepting idle state straight to the result state.
// A moving tick steps through S_LIMIT, S_STEP, S_SPEED, S_DIST, S_POS and S_WRD, then S_WCHK
// when the segment walk reads the memory, repeating S_WRD and S_WCHK for each crossed segment
// that does not end the route; the single memory read port and the two multiplies set the cost.
// Reset is asynchronous and needs no clearing pass; the segment memory holds
// garbage until loaded. The receiver cannot stall; busy_o is high from the
// accepting edge through the cycle in which done_o is shown.
module vehicle_route_kinematics_step #(
  parameter int unsigned MAX_SEGMENTS = vrk_pkg::MaxSegments
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  vrk_pkg::in_item_t   in_item_i,
  output logic                done_o,
  output vrk_pkg::out_item_t  out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);

  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [6:0] SegMax = 7'(MAX_SEGMENTS);

  vrk_pkg::state_e  state_q, state_d;
  vrk_pkg::mode_e   mode_q, mode_d;
  vrk_pkg::status_e status_q, status_d;

  logic [15:0] max_speed_q, accel_q, decel_q;
  logic [31:0] pos_q, pos_d;
  logic [15:0] speed_q, speed_d;
  logic [6:0]  ridx_q, ridx_d, rcnt_q, rcnt_d;
  logic [31:0] spawn_q, spawn_d, elapsed_q, elapsed_d;
  logic [31:0] wait_q, wait_d, arrival_q, arrival_d;
  logic [15:0] dt_q, dt_d;
  logic [63:0] mask_q, mask_d;
  logic        fp_q, fp_d;
  logic [31:0] fmax_q, fmax_d;
  logic [15:0] fspeed_q, fspeed_d;
  logic [15:0] desired_q, desired_d;
  logic [31:0] prod_q, prod_d;

  logic [47:0] mem [MAX_SEGMENTS];
  logic [47:0] rd_q;
  logic        rd_en;
  logic        wr_en;

  logic        accept;
  logic        tick_go;
  logic [31:0] rd_len;
  logic [15:0] rd_lim;

  assign accept = start_i && (state_q == vrk_pkg::S_IDLE);
  assign busy_o = (state_q != vrk_pkg::S_IDLE);
  assign rd_len = rd_q[47:16];
  assign rd_lim = rd_q[15:0];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= vrk_pkg::MaxSpeedRst;
      accel_q     <= vrk_pkg::AccelRst;
      decel_q     <= vrk_pkg::DecelRst;
    end else if (cfg_we_i) begin
      unique case (vrk_pkg::cfg_idx_e'(cfg_idx_i))
        vrk_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_wdata_i;
        vrk_pkg::CFG_ACCEL:     accel_q     <= cfg_wdata_i;
        vrk_pkg::CFG_DECEL:     decel_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Segment memory: loads write only on accepting a load, and ticks read on accepting a moving tick
  // or while busy, so accesses never overlap.
  assign wr_en = accept && (vrk_pkg::cmd_e'(in_item_i.cmd) == vrk_pkg::CMD_LOAD)
                 && (in_item_i.index < SegMax);
  assign rd_en = (accept && tick_go) ||
                 (state_q == vrk_pkg::S_WRD && mode_q == vrk_pkg::MODE_DRIVING &&
                  ridx_q < rcnt_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[in_item_i.index[AW-1:0]] <= {in_item_i.segment_length,
                                       in_item_i.segment_speed_limit};
    end
    if (rd_en) begin
      rd_q <= mem[ridx_q[AW-1:0]];
    end
  end

  // Tick front end, evaluated on the accepted item.
  logic [32:0]     elap_sum;
  logic [31:0]     room;
  logic [32:0]     wait_sum;
  logic            elap_ovf;
  vrk_pkg::mode_e  mode_res;
  logic            tick_reject;
  logic            tick_idle;

  always_comb begin
    room        = ~spawn_q;
    elap_sum    = {1'b0, elapsed_q} + {17'd0, in_item_i.delta_t};
    elap_ovf    = elap_sum > {1'b0, room};
    wait_sum    = {1'b0, wait_q} + {17'd0, in_item_i.delta_t};
    tick_reject = in_item_i.follow_present && (in_item_i.follow_max_position < pos_q);
    tick_idle   = (mode_q == vrk_pkg::MODE_SPAWNING) || (mode_q == vrk_pkg::MODE_ARRIVED);
    mode_res    = mode_q;
    if (mode_q == vrk_pkg::MODE_LIGHT && in_item_i.allows_mask[ridx_q[5:0]]) begin
      mode_res = vrk_pkg::MODE_DRIVING;
    end
    if (mode_q == vrk_pkg::MODE_WAITING &&
        !(in_item_i.follow_present && in_item_i.follow_max_position <= pos_q)) begin
      mode_res = vrk_pkg::MODE_DRIVING;
    end
    tick_go = (vrk_pkg::cmd_e'(in_item_i.cmd) == vrk_pkg::CMD_TICK) && !tick_reject &&
              !tick_idle && (mode_res == vrk_pkg::MODE_DRIVING) &&
              (in_item_i.delta_t != 16'd0);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vrk_pkg::S_IDLE:  if (accept) state_d = tick_go ? vrk_pkg::S_LIMIT : vrk_pkg::S_RESP;
      vrk_pkg::S_LIMIT: state_d = vrk_pkg::S_STEP;
      vrk_pkg::S_STEP:  state_d = vrk_pkg::S_SPEED;
      vrk_pkg::S_SPEED: state_d = vrk_pkg::S_DIST;
      vrk_pkg::S_DIST:  state_d = vrk_pkg::S_POS;
      vrk_pkg::S_POS:   state_d = vrk_pkg::S_WRD;
      vrk_pkg::S_WRD:   state_d = rd_en ? vrk_pkg::S_WCHK : vrk_pkg::S_RESP;
      vrk_pkg::S_WCHK: begin
        if (rd_len <= pos_q && mask_q[ridx_q[5:0]] && (ridx_q + 7'd1) < rcnt_q) begin
          state_d = vrk_pkg::S_WRD;
        end else begin
          state_d = vrk_pkg::S_RESP;
        end
      end
      vrk_pkg::S_RESP:  state_d = vrk_pkg::S_IDLE;
      default:          state_d = vrk_pkg::S_IDLE;
    endcase
  end

  // Datapath next values.
  logic [22:0] step_ext;
  logic [32:0] pos_sum;
  logic [15:0] dmin;

  always_comb begin
    mode_d = mode_q;  status_d = status_q;
    pos_d = pos_q;  speed_d = speed_q;  ridx_d = ridx_q;  rcnt_d = rcnt_q;
    spawn_d = spawn_q;  elapsed_d = elapsed_q;  wait_d = wait_q;  arrival_d = arrival_q;
    dt_d = dt_q;  mask_d = mask_q;  fp_d = fp_q;  fmax_d = fmax_q;  fspeed_d = fspeed_q;
    desired_d = desired_q;  prod_d = prod_q;
    step_ext = {1'b0, prod_q[31:10]};
    pos_sum  = {1'b0, pos_q} + {11'd0, prod_q[31:10]};
    dmin     = (rd_lim < max_speed_q) ? rd_lim : max_speed_q;

    unique case (state_q)
      vrk_pkg::S_IDLE: begin
        if (accept) begin
          status_d = vrk_pkg::ST_OK;
          dt_d = in_item_i.delta_t;  mask_d = in_item_i.allows_mask;
          fp_d = in_item_i.follow_present;  fmax_d = in_item_i.follow_max_position;
          fspeed_d = in_item_i.follow_speed_limit;
          unique case (vrk_pkg::cmd_e'(in_item_i.cmd))
            vrk_pkg::CMD_START: begin
              if (mode_q != vrk_pkg::MODE_SPAWNING || in_item_i.index > SegMax) begin
                status_d = vrk_pkg::ST_REJECT;
              end else begin
                spawn_d = in_item_i.spawn_time;
                rcnt_d  = in_item_i.index;
                ridx_d  = 7'd0;
                if (in_item_i.index == 7'd0) begin
                  mode_d    = vrk_pkg::MODE_ARRIVED;
                  arrival_d = in_item_i.spawn_time;
                end else begin
                  mode_d = vrk_pkg::MODE_DRIVING;
                end
              end
            end
            vrk_pkg::CMD_TICK: begin
              if (tick_reject) begin
                status_d = vrk_pkg::ST_BEHIND;
              end else if (!tick_idle) begin
                if (elap_ovf) begin
                  elapsed_d = room;
                  status_d  = vrk_pkg::ST_OVERFLOW;
                end else begin
                  elapsed_d = elap_sum[31:0];
                end
                mode_d = mode_res;
                if (mode_res == vrk_pkg::MODE_WAITING || mode_res == vrk_pkg::MODE_LIGHT) begin
                  if (wait_sum[32]) begin
                    wait_d   = '1;
                    status_d = vrk_pkg::ST_OVERFLOW;
                  end else begin
                    wait_d = wait_sum[31:0];
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      vrk_pkg::S_LIMIT: begin
        desired_d = (fp_q && fspeed_q < dmin) ? fspeed_q : dmin;
      end
      vrk_pkg::S_STEP: begin
        prod_d = ((speed_q < desired_q) ? accel_q : decel_q) * dt_q;
      end
      vrk_pkg::S_SPEED: begin
        if (speed_q < desired_q) begin
          if ({7'd0, speed_q} + step_ext >= {7'd0, desired_q}) speed_d = desired_q;
          else speed_d = speed_q + step_ext[15:0];
        end else if (speed_q > desired_q) begin
          if (step_ext >= {7'd0, speed_q - desired_q}) speed_d = desired_q;
          else speed_d = speed_q - step_ext[15:0];
        end
      end
      vrk_pkg::S_DIST: begin
        prod_d = speed_q * dt_q;
      end
      vrk_pkg::S_POS: begin
        pos_d = pos_sum[32] ? '1 : pos_sum[31:0];
        if (fp_q && pos_d >= fmax_q) begin
          pos_d   = fmax_q;
          speed_d = 16'd0;
          mode_d  = vrk_pkg::MODE_WAITING;
        end
      end
      vrk_pkg::S_WRD: begin
        if (mode_q == vrk_pkg::MODE_DRIVING && ridx_q >= rcnt_q) begin
          mode_d = vrk_pkg::MODE_ARRIVED;  arrival_d = spawn_q + elapsed_q;
          pos_d = 32'd0;  speed_d = 16'd0;
        end
      end
      vrk_pkg::S_WCHK: begin
        if (rd_len <= pos_q) begin
          if (!mask_q[ridx_q[5:0]]) begin
            pos_d = rd_len;  speed_d = 16'd0;  mode_d = vrk_pkg::MODE_LIGHT;
          end else begin
            pos_d  = pos_q - rd_len;
            ridx_d = ridx_q + 7'd1;
            if (ridx_d >= rcnt_q) begin
              mode_d = vrk_pkg::MODE_ARRIVED;  arrival_d = spawn_q + elapsed_q;
              pos_d = 32'd0;  speed_d = 16'd0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vrk_pkg::S_IDLE;   mode_q <= vrk_pkg::MODE_SPAWNING;
      status_q <= vrk_pkg::ST_OK;
      pos_q <= '0;  speed_q <= '0;  ridx_q <= '0;  rcnt_q <= '0;
      spawn_q <= '0;  elapsed_q <= '0;  wait_q <= '0;  arrival_q <= '0;
    end else begin
      state_q <= state_d;  mode_q <= mode_d;  status_q <= status_d;
      pos_q <= pos_d;  speed_q <= speed_d;  ridx_q <= ridx_d;  rcnt_q <= rcnt_d;
      spawn_q <= spawn_d;  elapsed_q <= elapsed_d;  wait_q <= wait_d;
      arrival_q <= arrival_d;
    end
  end

  // Per-item operands and products; no reset needed.
  always_ff @(posedge clk_i) begin
    dt_q <= dt_d;  mask_q <= mask_d;  fp_q <= fp_d;  fmax_q <= fmax_d;
    fspeed_q <= fspeed_d;  desired_q <= desired_d;  prod_q <= prod_d;
  end

  // Result item, shown for the one response cycle.
  always_comb begin
    done_o = (state_q == vrk_pkg::S_RESP);
    out_item_o.status         = status_q;
    out_item_o.mode           = mode_q;
    out_item_o.position       = pos_q;
    out_item_o.speed          = speed_q;
    out_item_o.route_position = ridx_q;
    out_item_o.waiting_time   = wait_q;
    out_item_o.arrival_time   = (mode_q == vrk_pkg::MODE_ARRIVED) ? arrival_q : 32'd0;
  end

`include "vehicle_route_kinematics_step_defines.svh"

  `VRK_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `VRK_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `VRK_ASSERT_NOW(a_arrival_zero, mode_q != vrk_pkg::MODE_ARRIVED, out_item_o.arrival_time == '0)
  `VRK_ASSERT_NOW(a_walk_in_range, state_q == vrk_pkg::S_WCHK, ridx_q < rcnt_q)

endmodule

FILE: bench/tb_vehicle_route_kinematics_step.sv
// Self-checking testbench of the vehicle route kinematics block with its own kinematics predictor.
module tb_vehicle_route_kinematics_step;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  vrk_pkg::in_item_t   in_item_i = '0;
  logic                done_o;
  vrk_pkg::out_item_t  out_item_o;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = vrk_pkg::CFG_MAX_SPEED;
  logic [15:0]         cfg_wdata_i = '0;

  vehicle_route_kinematics_step dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_item_i, .done_o, .out_item_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // Predicted vehicle state and configuration.
  logic [15:0]    veh_max_speed = vrk_pkg::MaxSpeedRst;
  logic [15:0]    veh_accel     = vrk_pkg::AccelRst;
  logic [15:0]    veh_decel     = vrk_pkg::DecelRst;
  vrk_pkg::mode_e veh_mode      = vrk_pkg::MODE_SPAWNING;
  logic [31:0]    veh_pos       = '0;
  logic [15:0]    veh_speed     = '0;
  logic [6:0]     veh_seg       = '0;
  logic [6:0]     veh_count     = '0;
  logic [31:0]    seg_len_tab [vrk_pkg::MaxSegments];
  logic [15:0]    seg_lim_tab [vrk_pkg::MaxSegments];
  logic [31:0]    veh_spawn     = '0;
  logic [31:0]    veh_elapsed   = '0;
  logic [31:0]    veh_waiting   = '0;
  logic [31:0]    veh_arrival   = '0;

  vrk_pkg::in_item_t  pending_items [$];
  vrk_pkg::out_item_t expected_reports [$];
  bit        in_flight = 0;
  bit        quiet = 0;
  int        gap_left = 0;
  int        n_items = 0, n_checked = 0, n_mismatch = 0, n_phases = 0;
  int        n_overflow = 0, n_behind = 0, n_light = 0, n_arrived = 0;

  // Walk across completed segments, stopping at closed lights.
  function automatic void walk_route(logic [63:0] mask);
    for (int g = 0; g <= vrk_pkg::MaxSegments; g++) begin
      if (veh_mode != vrk_pkg::MODE_DRIVING) break;
      if (veh_seg >= veh_count) begin
        veh_mode = vrk_pkg::MODE_ARRIVED;
        veh_arrival = veh_spawn + veh_elapsed;
        veh_pos = '0;
        veh_speed = '0;
        break;
      end
      if (veh_pos < seg_len_tab[veh_seg[5:0]]) break;
      if (!mask[veh_seg[5:0]]) begin
        veh_pos = seg_len_tab[veh_seg[5:0]];
        veh_speed = '0;
        veh_mode = vrk_pkg::MODE_LIGHT;
        break;
      end
      veh_pos = veh_pos - seg_len_tab[veh_seg[5:0]];
      veh_seg = veh_seg + 7'd1;
      if (veh_seg >= veh_count) begin
        veh_mode = vrk_pkg::MODE_ARRIVED;
        veh_arrival = veh_spawn + veh_elapsed;
        veh_pos = '0;
        veh_speed = '0;
      end
    end
  endfunction

  // Advance the vehicle by one tick item.
  function automatic vrk_pkg::status_e tick_vehicle(vrk_pkg::in_item_t it);
    vrk_pkg::status_e st = vrk_pkg::ST_OK;
    logic [63:0] dt = {48'd0, it.delta_t};
    logic [63:0] room, nxt, w, step, pos;
    logic [15:0] desired;
    if (it.follow_present && it.follow_max_position < veh_pos) return vrk_pkg::ST_BEHIND;
    if (veh_mode == vrk_pkg::MODE_SPAWNING || veh_mode == vrk_pkg::MODE_ARRIVED)
      return vrk_pkg::ST_OK;
    room = 64'hFFFF_FFFF - {32'd0, veh_spawn};
    nxt = {32'd0, veh_elapsed} + dt;
    if (nxt > room) begin
      nxt = room;
      st = vrk_pkg::ST_OVERFLOW;
    end
    veh_elapsed = nxt[31:0];
    if (veh_mode == vrk_pkg::MODE_LIGHT && it.allows_mask[veh_seg[5:0]])
      veh_mode = vrk_pkg::MODE_DRIVING;
    if (veh_mode == vrk_pkg::MODE_WAITING &&
        !(it.follow_present && it.follow_max_position <= veh_pos))
      veh_mode = vrk_pkg::MODE_DRIVING;
    if (veh_mode == vrk_pkg::MODE_WAITING || veh_mode == vrk_pkg::MODE_LIGHT) begin
      w = {32'd0, veh_waiting} + dt;
      if (w > 64'hFFFF_FFFF) begin
        w = 64'hFFFF_FFFF;
        st = vrk_pkg::ST_OVERFLOW;
      end
      veh_waiting = w[31:0];
    end
    if (veh_mode != vrk_pkg::MODE_DRIVING || dt == 0) return st;
    // Target speed is the tightest of the three caps.
    desired = veh_max_speed;
    if (seg_lim_tab[veh_seg[5:0]] < desired) desired = seg_lim_tab[veh_seg[5:0]];
    if (it.follow_present && it.follow_speed_limit < desired) desired = it.follow_speed_limit;
    if (veh_speed < desired) begin
      step = ({48'd0, veh_accel} * dt) >> 10;
      if ({48'd0, veh_speed} + step >= {48'd0, desired}) veh_speed = desired;
      else veh_speed = veh_speed + step[15:0];
    end else if (veh_speed > desired) begin
      step = ({48'd0, veh_decel} * dt) >> 10;
      if (step >= {48'd0, veh_speed - desired}) veh_speed = desired;
      else veh_speed = veh_speed - step[15:0];
    end
    pos = {32'd0, veh_pos} + (({48'd0, veh_speed} * dt) >> 10);
    if (pos > 64'hFFFF_FFFF) pos = 64'hFFFF_FFFF;
    veh_pos = pos[31:0];
    if (it.follow_present && veh_pos >= it.follow_max_position) begin
      veh_pos = it.follow_max_position;
      veh_speed = '0;
      veh_mode = vrk_pkg::MODE_WAITING;
    end
    walk_route(it.allows_mask);
    return st;
  endfunction

  // Expected report for one accepted item.
  function automatic vrk_pkg::out_item_t predict_report(vrk_pkg::in_item_t it);
    vrk_pkg::status_e   st = vrk_pkg::ST_OK;
    vrk_pkg::out_item_t r;
    case (it.cmd)
      vrk_pkg::CMD_LOAD: begin
        if (it.index < vrk_pkg::MaxSegments) begin
          seg_len_tab[it.index[5:0]] = it.segment_length;
          seg_lim_tab[it.index[5:0]] = it.segment_speed_limit;
        end
      end
      vrk_pkg::CMD_START: begin
        if (veh_mode != vrk_pkg::MODE_SPAWNING || it.index > vrk_pkg::MaxSegments) begin
          st = vrk_pkg::ST_REJECT;
        end else begin
          veh_spawn = it.spawn_time;
          veh_count = it.index;
          veh_seg = '0;
          if (it.index == 0) begin
            veh_mode = vrk_pkg::MODE_ARRIVED;
            veh_arrival = veh_spawn;
          end else begin
            veh_mode = vrk_pkg::MODE_DRIVING;
          end
        end
      end
      vrk_pkg::CMD_TICK: st = tick_vehicle(it);
      default: ;
    endcase
    r.status = st;
    r.mode = veh_mode;
    r.position = veh_pos;
    r.speed = veh_speed;
    r.route_position = veh_seg;
    r.waiting_time = veh_waiting;
    r.arrival_time = (veh_mode == vrk_pkg::MODE_ARRIVED) ? veh_arrival : 32'd0;
    return r;
  endfunction

  // Driver: presents pending items with random gaps and records each accepted one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_reports.insert(expected_reports.size(), predict_report(in_item_i));
        in_flight = 0;
      end
      if (start_i && busy_o) begin
        // Hold the item until the block takes it.
      end else if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        if (!quiet && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 19) - 1;
          start_i <= 1'b0;
        end else begin
          in_item_i <= pending_items.pop_front();
          start_i <= 1'b1;
          in_flight = 1;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: compares each report with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_reports.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("ERROR: unexpected report %p", out_item_o);
      end else begin
        vrk_pkg::out_item_t exp_r;
        exp_r = expected_reports.pop_front();
        n_checked++;
        if (exp_r.status == vrk_pkg::ST_OVERFLOW) n_overflow++;
        if (exp_r.status == vrk_pkg::ST_BEHIND) n_behind++;
        if (exp_r.mode == vrk_pkg::MODE_LIGHT) n_light++;
        if (exp_r.mode == vrk_pkg::MODE_ARRIVED) n_arrived++;
        if (out_item_o !== exp_r) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"ERROR: report %0d: status %0d/%0d mode %0d/%0d pos %0d/%0d ",
                      "speed %0d/%0d seg %0d/%0d wait %0d/%0d arr %0d/%0d (exp/got)"},
                     n_checked, exp_r.status, out_item_o.status, exp_r.mode,
                     out_item_o.mode, exp_r.position, out_item_o.position, exp_r.speed,
                     out_item_o.speed, exp_r.route_position, out_item_o.route_position,
                     exp_r.waiting_time, out_item_o.waiting_time, exp_r.arrival_time,
                     out_item_o.arrival_time);
        end
      end
    end
  end

  // Wait until the previous item has been taken.
  task automatic wait_slot();
    while (pending_items.size() != 0 || in_flight) @(negedge clk_i);
  endtask

  // Queue one item once the previous one has been taken.
  task automatic push_item(vrk_pkg::in_item_t it);
    wait_slot();
    pending_items.insert(pending_items.size(), it);
    n_items++;
  endtask

  // Wait until every report has arrived and the block has settled.
  task automatic drain();
    while (pending_items.size() != 0 || in_flight || start_i || expected_reports.size() != 0)
      @(negedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic cfg_write(vrk_pkg::cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      vrk_pkg::CFG_MAX_SPEED: veh_max_speed = val;
      vrk_pkg::CFG_ACCEL:     veh_accel = val;
      vrk_pkg::CFG_DECEL:     veh_decel = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Fully random fields, used as noise in the parts a command ignores.
  function automatic vrk_pkg::in_item_t noise_item();
    vrk_pkg::in_item_t it;
    it.cmd = vrk_pkg::CMD_NONE;
    it.index = 7'($urandom);
    it.segment_length = $urandom;
    it.segment_speed_limit = 16'($urandom);
    it.spawn_time = $urandom;
    it.delta_t = 16'($urandom);
    it.allows_mask = {$urandom, $urandom};
    it.follow_present = 1'($urandom);
    it.follow_max_position = $urandom;
    it.follow_speed_limit = 16'($urandom);
    return it;
  endfunction

  // A mostly well-formed item drawn against the current vehicle state.
  function automatic vrk_pkg::in_item_t random_item();
    vrk_pkg::in_item_t it = noise_item();
    int          sel = $urandom_range(0, 99);
    int          r;
    logic [63:0] far;
    if (sel < 80) begin
      it.cmd = vrk_pkg::CMD_TICK;
      r = $urandom_range(0, 19);
      if (r == 0) it.delta_t = '0;
      else if (r == 1) it.delta_t = 16'hFFFF;
      else if (r > 4) it.delta_t = 16'($urandom_range(1, 1500));
      r = $urandom_range(0, 9);
      it.follow_present = (r >= 5);
      if (r == 5 || r == 6) begin
        far = {32'd0, veh_pos} + 64'($urandom_range(0, 400000));
        it.follow_max_position = (far > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : far[31:0];
      end else if (r == 7) begin
        it.follow_max_position = veh_pos;
      end else if (r == 8 && veh_pos > 0) begin
        it.follow_max_position = veh_pos - $urandom_range(1, veh_pos > 1000 ? 1000 : veh_pos);
      end
      if ($urandom_range(0, 1)) it.follow_speed_limit = 16'($urandom_range(0, veh_max_speed));
      it.allows_mask[veh_seg[5:0]] = ($urandom_range(0, 9) >= 3);
    end else if (sel < 88) begin
      it.cmd = vrk_pkg::CMD_LOAD;
      it.index = 7'($urandom_range(0, 127));
      if (it.index < vrk_pkg::MaxSegments) begin
        it.segment_length = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 100)
                                                         : $urandom_range(20000, 2000000);
        it.segment_speed_limit = 16'($urandom_range(500, 65535));
      end
    end else if (sel < 94) begin
      it.cmd = vrk_pkg::CMD_START;
    end
    return it;
  endfunction

  // Stimulus: route setup, directed corner items, then random phases.
  initial begin
    vrk_pkg::in_item_t it;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    cfg_write(vrk_pkg::CFG_MAX_SPEED, vrk_pkg::MaxSpeedRst);
    cfg_write(vrk_pkg::CFG_ACCEL, vrk_pkg::AccelRst);
    cfg_write(vrk_pkg::CFG_DECEL, vrk_pkg::DecelRst);
    cfg_write(vrk_pkg::CFG_UNUSED, 16'hFFFF);
    n_phases++;

    // Corner cases before the vehicle exists.
    it = noise_item(); it.cmd = vrk_pkg::CMD_LOAD; it.index = 7'd64; push_item(it);
    it = noise_item(); it.cmd = vrk_pkg::CMD_LOAD; it.index = 7'd127;
    it.segment_length = '1; it.segment_speed_limit = '1; push_item(it);
    it = noise_item(); it.cmd = vrk_pkg::CMD_NONE; push_item(it);
    it = noise_item(); it.cmd = vrk_pkg::CMD_TICK; it.follow_present = 1'b0; push_item(it);
    it = noise_item(); it.cmd = vrk_pkg::CMD_START; it.index = 7'd65; push_item(it);
    it = noise_item(); it.cmd = vrk_pkg::CMD_START; it.index = 7'd127; push_item(it);
    it = noise_item(); it.cmd = vrk_pkg::CMD_LOAD; it.index = 7'd63;
    it.segment_length = '1; it.segment_speed_limit = '0; push_item(it);

    // Fill the whole route, with a zero-length segment and some short ones.
    for (int s = 0; s < vrk_pkg::MaxSegments; s++) begin
      it = noise_item();
      it.cmd = vrk_pkg::CMD_LOAD;
      it.index = 7'(s);
      it.segment_length = (s == 3) ? 32'd0 :
                          (s % 5 == 1) ? $urandom_range(1, 100) : $urandom_range(20000, 2000000);
      it.segment_speed_limit = (s == 10) ? 16'hFFFF : 16'($urandom_range(500, 65535));
      push_item(it);
    end

    // The one accepted start, placed near the end of the time range.
    it = noise_item(); it.cmd = vrk_pkg::CMD_START; it.index = 7'd64;
    it.spawn_time = 32'hFFFF_FFFF - $urandom_range(200000, 500000); push_item(it);
    it = noise_item(); it.cmd = vrk_pkg::CMD_START; it.index = 7'd5; push_item(it);
    it = noise_item(); it.cmd = vrk_pkg::CMD_TICK; it.follow_present = 1'b0;
    it.delta_t = '0; push_item(it);
    it = noise_item(); it.cmd = vrk_pkg::CMD_TICK; it.follow_present = 1'b1;
    it.follow_max_position = '0; it.delta_t = 16'hFFFF; push_item(it);
    it = noise_item(); it.cmd = vrk_pkg::CMD_TICK; it.follow_present = 1'b0;
    it.delta_t = 16'd1024; it.allows_mask = '1; push_item(it);

    // Random phases over several settings, the extremes among them.
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: ;
        1: begin
          cfg_write(vrk_pkg::CFG_MAX_SPEED, 16'hFFFF);
          cfg_write(vrk_pkg::CFG_ACCEL, 16'hFFFF);
          cfg_write(vrk_pkg::CFG_DECEL, 16'hFFFF);
        end
        2: begin
          cfg_write(vrk_pkg::CFG_MAX_SPEED, 16'd1);
          cfg_write(vrk_pkg::CFG_ACCEL, 16'd1);
          cfg_write(vrk_pkg::CFG_DECEL, 16'd1);
        end
        default: begin
          cfg_write(vrk_pkg::CFG_MAX_SPEED, 16'($urandom_range(1, 65535)));
          cfg_write(vrk_pkg::CFG_ACCEL, 16'($urandom_range(1, 65535)));
          cfg_write(vrk_pkg::CFG_DECEL, 16'($urandom_range(1, 65535)));
        end
      endcase
      n_phases++;
      quiet = (p == 5);
      // Each item is drawn only after the previous one has been taken.
      for (int k = 0; k < 110; k++) begin
        wait_slot();
        push_item(random_item());
      end
    end

    drain();
    $display("Checked %0d reports from %0d items across %0d configuration settings.",
             n_checked, n_items, n_phases);
    $display("Saw %0d overflow, %0d follow-behind, %0d light-stop and %0d arrived reports.",
             n_overflow, n_behind, n_light, n_arrived);
    if (n_mismatch == 0 && expected_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #50ms;
    $display("Timeout with %0d reports outstanding", expected_reports.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule
